// ----- sv/gdad_pkg.sv -----
// Shared types, constants, calendar helpers and the control store of the date adder.
package gdad_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned AddW   = 15;
  // Years can run about a hundred past the 14-bit field before the output keeps only its low 14 bits.
  localparam int unsigned YearIntW = YearW + 1;
  // Largest remainder is 31 + 335 + 32767, which fits in 16 bits.
  localparam int unsigned RemW   = 16;
  localparam int unsigned PcW    = 4;
  localparam int unsigned ArgW   = 3;

  localparam logic [YearW-1:0]  Cycle400   = YearW'(400);
  localparam logic [8:0]        Cent1      = 9'd100;
  localparam logic [8:0]        Cent2      = 9'd200;
  localparam logic [8:0]        Cent3      = 9'd300;
  localparam logic [8:0]        LastOfCycle = 9'd399;
  localparam logic [MonthW-1:0] MonthJan   = MonthW'(1);
  localparam logic [MonthW-1:0] MonthFeb   = MonthW'(2);
  localparam logic [MonthW-1:0] MonthApr   = MonthW'(4);
  localparam logic [MonthW-1:0] MonthJun   = MonthW'(6);
  localparam logic [MonthW-1:0] MonthSep   = MonthW'(9);
  localparam logic [MonthW-1:0] MonthNov   = MonthW'(11);
  localparam logic [MonthW-1:0] MonthDec   = MonthW'(12);
  localparam logic [DayW-1:0]   Len28      = DayW'(28);
  localparam logic [DayW-1:0]   Len29      = DayW'(29);
  localparam logic [DayW-1:0]   Len30      = DayW'(30);
  localparam logic [DayW-1:0]   Len31      = DayW'(31);

  typedef enum logic [2:0] {
    OP_WAIT,   // take an item; jump when the month is invalid
    OP_MOD,    // conditional subtract of 400 << arg from the year residue
    OP_SUM,    // add lengths of the months before the start month
    OP_ADD,    // add the day count and restart at January
    OP_SUB,    // peel off one month per cycle
    OP_OUT     // hand the result to the output register
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [ArgW-1:0] arg;
    logic [PcW-1:0]  nxt;
  } uword_t;

  localparam logic [PcW-1:0] PcWait = PcW'(0);
  localparam logic [PcW-1:0] PcOut  = PcW'(10);

  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{op: OP_OUT, arg: '0, nxt: PcWait};
    case (pc)
      PcW'(0):  w = '{op: OP_WAIT, arg: ArgW'(0), nxt: PcOut};
      PcW'(1):  w = '{op: OP_MOD,  arg: ArgW'(5), nxt: PcW'(2)};
      PcW'(2):  w = '{op: OP_MOD,  arg: ArgW'(4), nxt: PcW'(3)};
      PcW'(3):  w = '{op: OP_MOD,  arg: ArgW'(3), nxt: PcW'(4)};
      PcW'(4):  w = '{op: OP_MOD,  arg: ArgW'(2), nxt: PcW'(5)};
      PcW'(5):  w = '{op: OP_MOD,  arg: ArgW'(1), nxt: PcW'(6)};
      PcW'(6):  w = '{op: OP_MOD,  arg: ArgW'(0), nxt: PcW'(7)};
      PcW'(7):  w = '{op: OP_SUM,  arg: ArgW'(0), nxt: PcW'(8)};
      PcW'(8):  w = '{op: OP_ADD,  arg: ArgW'(0), nxt: PcW'(9)};
      PcW'(9):  w = '{op: OP_SUB,  arg: ArgW'(0), nxt: PcOut};
      PcW'(10): w = '{op: OP_OUT,  arg: ArgW'(0), nxt: PcWait};
      default:  w = '{op: OP_OUT,  arg: ArgW'(0), nxt: PcWait};
    endcase
    return w;
  endfunction

  // The residue is the year modulo 400, so it also settles the rules for 4 and 100.
  function automatic logic is_leap(input logic [8:0] ymod);
    return (ymod[1:0] == 2'b00) && (ymod != Cent1) && (ymod != Cent2) && (ymod != Cent3);
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    len = Len31;
    case (m)
      MonthFeb: len = leap ? Len29 : Len28;
      MonthApr: len = Len30;
      MonthJun: len = Len30;
      MonthSep: len = Len30;
      MonthNov: len = Len30;
      default:  len = Len31;
    endcase
    return len;
  endfunction

endpackage

// ----- sv/gregorian_date_add_days.sv -----
// Top level of the date adder: a microcoded sequencer over a small date datapath.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------------
//   in      | input     | in_valid_i / in_ready_o | start_year, start_month, start_day, days_to_add
//   out     | output    | out_valid_o / out_ready_i | result_year, result_month, result_day, bad_month
//
// An item goes from the wait step through the year-residue, month-sum, add and subtract steps to
// the output step. The subtract step peels off N months, one per cycle: N is the number of whole
// months stepped over from January of the start year and reaches about 1100 for the largest day
// count. An invalid month jumps from the wait step to the output step. Reset clears the program
// counter and the output valid flag. The result sits in an output register, so a new item is
// taken while it waits; the sequencer stalls in its output step only if that register is full.
module gregorian_date_add_days (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gdad_pkg::YearW-1:0]    start_year_i,
  input  logic [gdad_pkg::MonthW-1:0]   start_month_i,
  input  logic [gdad_pkg::DayW-1:0]     start_day_i,
  input  logic [gdad_pkg::AddW-1:0]     days_to_add_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gdad_pkg::YearW-1:0]    result_year_o,
  output logic [gdad_pkg::MonthW-1:0]   result_month_o,
  output logic [gdad_pkg::DayW-1:0]     result_day_o,
  output logic                          bad_month_o
);

  logic [gdad_pkg::PcW-1:0]      pc_q, pc_d;
  logic [gdad_pkg::YearIntW-1:0] year_q, year_d;
  logic [gdad_pkg::YearW-1:0]    ymod_q, ymod_d;
  logic [gdad_pkg::MonthW-1:0]   month_q, month_d;
  logic [gdad_pkg::MonthW-1:0]   m_q, m_d;
  logic [gdad_pkg::RemW-1:0]     rem_q, rem_d;
  logic [gdad_pkg::AddW-1:0]     add_q, add_d;
  logic                          bad_q, bad_d;

  logic                          ovalid_q, ovalid_d;
  logic [gdad_pkg::YearW-1:0]    oyear_q, oyear_d;
  logic [gdad_pkg::MonthW-1:0]   omonth_q, omonth_d;
  logic [gdad_pkg::DayW-1:0]     oday_q, oday_d;
  logic                          obad_q, obad_d;

  gdad_pkg::uword_t              uw;
  logic                          leap;
  logic [gdad_pkg::DayW-1:0]     mlen;
  logic [gdad_pkg::YearW:0]      mod_sub;
  logic                          slot_free;
  logic                          in_bad;

  assign uw        = gdad_pkg::ucode(pc_q);
  assign leap      = gdad_pkg::is_leap(ymod_q[8:0]);
  assign mlen      = gdad_pkg::month_len(m_q, leap);
  assign mod_sub   = (gdad_pkg::YearW+1)'(gdad_pkg::Cycle400) << uw.arg;
  assign slot_free = !ovalid_q || out_ready_i;
  assign in_bad    = (start_month_i < gdad_pkg::MonthJan) || (start_month_i > gdad_pkg::MonthDec);
  assign in_ready_o = (uw.op == gdad_pkg::OP_WAIT);

  always_comb begin
    pc_d     = pc_q;
    year_d   = year_q;
    ymod_d   = ymod_q;
    month_d  = month_q;
    m_d      = m_q;
    rem_d    = rem_q;
    add_d    = add_q;
    bad_d    = bad_q;
    ovalid_d = ovalid_q && !out_ready_i;
    oyear_d  = oyear_q;
    omonth_d = omonth_q;
    oday_d   = oday_q;
    obad_d   = obad_q;

    case (uw.op)
      gdad_pkg::OP_WAIT: begin
        if (in_valid_i) begin
          year_d  = gdad_pkg::YearIntW'(start_year_i);
          ymod_d  = start_year_i;
          month_d = start_month_i;
          m_d     = gdad_pkg::MonthJan;
          rem_d   = gdad_pkg::RemW'(start_day_i);
          add_d   = days_to_add_i;
          bad_d   = in_bad;
          pc_d    = in_bad ? uw.nxt : pc_q + gdad_pkg::PcW'(1);
        end
      end
      gdad_pkg::OP_MOD: begin
        if ({1'b0, ymod_q} >= mod_sub) begin
          ymod_d = ymod_q - gdad_pkg::YearW'(mod_sub);
        end
        pc_d = uw.nxt;
      end
      gdad_pkg::OP_SUM: begin
        if (m_q < month_q) begin
          rem_d = rem_q + gdad_pkg::RemW'(mlen);
          m_d   = m_q + gdad_pkg::MonthW'(1);
        end else begin
          pc_d = uw.nxt;
        end
      end
      gdad_pkg::OP_ADD: begin
        rem_d = rem_q + gdad_pkg::RemW'(add_q);
        m_d   = gdad_pkg::MonthJan;
        pc_d  = uw.nxt;
      end
      gdad_pkg::OP_SUB: begin
        if (rem_q > gdad_pkg::RemW'(mlen)) begin
          rem_d = rem_q - gdad_pkg::RemW'(mlen);
          if (m_q == gdad_pkg::MonthDec) begin
            m_d    = gdad_pkg::MonthJan;
            year_d = year_q + gdad_pkg::YearIntW'(1);
            ymod_d = (ymod_q[8:0] == gdad_pkg::LastOfCycle) ? '0
                                                            : ymod_q + gdad_pkg::YearW'(1);
          end else begin
            m_d = m_q + gdad_pkg::MonthW'(1);
          end
        end else begin
          pc_d = uw.nxt;
        end
      end
      gdad_pkg::OP_OUT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          oyear_d  = year_q[gdad_pkg::YearW-1:0];
          omonth_d = bad_q ? month_q : m_q;
          oday_d   = rem_q[gdad_pkg::DayW-1:0];
          obad_d   = bad_q;
          pc_d     = uw.nxt;
        end
      end
      default: begin
        pc_d = gdad_pkg::PcWait;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= gdad_pkg::PcWait;
      ovalid_q <= 1'b0;
    end else begin
      pc_q     <= pc_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    year_q   <= year_d;
    ymod_q   <= ymod_d;
    month_q  <= month_d;
    m_q      <= m_d;
    rem_q    <= rem_d;
    add_q    <= add_d;
    bad_q    <= bad_d;
    oyear_q  <= oyear_d;
    omonth_q <= omonth_d;
    oday_q   <= oday_d;
    obad_q   <= obad_d;
  end

  assign out_valid_o    = ovalid_q;
  assign result_year_o  = oyear_q;
  assign result_month_o = omonth_q;
  assign result_day_o   = oday_q;
  assign bad_month_o    = obad_q;

endmodule

// ----- tb/sv/tb_gregorian_date_add_days.sv -----
// Self-checking testbench for the Gregorian date adder, with handshake stalls on both sides.
`timescale 1ns / 1ps

module tb_gregorian_date_add_days;

  localparam int unsigned MaxWait    = 18;
  localparam int unsigned DrainCyc   = 1200;
  localparam int unsigned CycleLimit = 3000000;

  typedef struct {
    logic [gdad_pkg::YearW-1:0]  year;
    logic [gdad_pkg::MonthW-1:0] month;
    logic [gdad_pkg::DayW-1:0]   day;
    logic [gdad_pkg::AddW-1:0]   add;
    int unsigned                 gap;
  } date_req_t;

  typedef struct {
    logic [gdad_pkg::YearW-1:0]  year;
    logic [gdad_pkg::MonthW-1:0] month;
    logic [gdad_pkg::DayW-1:0]   day;
    logic                        bad;
  } date_res_t;

  logic clk_i;
  logic rst_ni;

  logic                        in_valid;
  logic                        in_ready;
  logic [gdad_pkg::YearW-1:0]  start_year;
  logic [gdad_pkg::MonthW-1:0] start_month;
  logic [gdad_pkg::DayW-1:0]   start_day;
  logic [gdad_pkg::AddW-1:0]   days_to_add;
  logic                        out_valid;
  logic                        out_ready;
  logic [gdad_pkg::YearW-1:0]  result_year;
  logic [gdad_pkg::MonthW-1:0] result_month;
  logic [gdad_pkg::DayW-1:0]   result_day;
  logic                        bad_month;

  date_req_t   pending_dates_q[$];
  date_res_t   expected_dates_q[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned send_wait_left;
  int unsigned recv_wait_left;
  bit          send_quiet;
  bit          recv_quiet;

  gregorian_date_add_days u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .start_year_i   (start_year),
    .start_month_i  (start_month),
    .start_day_i    (start_day),
    .days_to_add_i  (days_to_add),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_year_o  (result_year),
    .result_month_o (result_month),
    .result_day_o   (result_day),
    .bad_month_o    (bad_month)
  );

  function automatic bit greg_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned greg_month_days(int unsigned y, int unsigned m);
    if (m == gdad_pkg::MonthFeb) return greg_leap(y) ? 29 : 28;
    if (m == gdad_pkg::MonthApr || m == gdad_pkg::MonthJun ||
        m == gdad_pkg::MonthSep || m == gdad_pkg::MonthNov) return 30;
    return 31;
  endfunction

  // Walks the month table forward from January; the year is kept wide until the end.
  function automatic date_res_t predict_date_sum(date_req_t d);
    date_res_t   r;
    int unsigned yr;
    int unsigned rem;
    int unsigned mo;
    int unsigned len;
    r.year  = d.year;
    r.month = d.month;
    r.day   = d.day;
    r.bad   = 1'b1;
    if (d.month < gdad_pkg::MonthJan || d.month > gdad_pkg::MonthDec) return r;
    yr  = d.year;
    rem = d.day;
    for (mo = gdad_pkg::MonthJan; mo < d.month; mo++) rem += greg_month_days(yr, mo);
    rem += d.add;
    mo  = gdad_pkg::MonthJan;
    len = greg_month_days(yr, mo);
    while (rem > len) begin
      rem -= len;
      mo++;
      if (mo > gdad_pkg::MonthDec) begin
        mo = gdad_pkg::MonthJan;
        yr++;
      end
      len = greg_month_days(yr, mo);
    end
    r.year  = gdad_pkg::YearW'(yr);
    r.month = gdad_pkg::MonthW'(mo);
    r.day   = gdad_pkg::DayW'(rem);
    r.bad   = 1'b0;
    return r;
  endfunction

  function automatic int unsigned draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, MaxWait);
  endfunction

  task automatic queue_date(int unsigned y, int unsigned m, int unsigned d, int unsigned a);
    date_req_t r;
    r.year  = gdad_pkg::YearW'(y);
    r.month = gdad_pkg::MonthW'(m);
    r.day   = gdad_pkg::DayW'(d);
    r.add   = gdad_pkg::AddW'(a);
    r.gap   = draw_wait(send_quiet);
    pending_dates_q.push_back(r);
  endtask

  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
    mismatch_cnt++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("gregorian_date_add_days regression: fail");
      $finish;
    end
  end

  // Sender: the next item goes out straight away when its gap is zero, so valid stays high.
  always @(posedge clk_i or negedge rst_ni) begin
    date_req_t nxt;
    if (!rst_ni) begin
      in_valid       <= 1'b0;
      start_year     <= '0;
      start_month    <= '0;
      start_day      <= '0;
      days_to_add    <= '0;
      send_wait_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        nxt.year  = start_year;
        nxt.month = start_month;
        nxt.day   = start_day;
        nxt.add   = days_to_add;
        nxt.gap   = 0;
        expected_dates_q.push_back(predict_date_sum(nxt));
      end
      if (!in_valid || in_ready) begin
        if (in_valid && pending_dates_q.size() != 0 && pending_dates_q[0].gap != 0) begin
          in_valid       <= 1'b0;
          send_wait_left <= pending_dates_q[0].gap - 1;
        end else if (send_wait_left != 0) begin
          in_valid       <= 1'b0;
          send_wait_left <= send_wait_left - 1;
        end else if (pending_dates_q.size() != 0) begin
          nxt = pending_dates_q.pop_front();
          in_valid    <= 1'b1;
          start_year  <= nxt.year;
          start_month <= nxt.month;
          start_day   <= nxt.day;
          days_to_add <= nxt.add;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: after each accepted result, ready may be dropped for a random wait, which is zero in quiet spells.
  always @(posedge clk_i or negedge rst_ni) begin
    date_res_t   exp_r;
    int unsigned w;
    if (!rst_ni) begin
      out_ready      <= 1'b0;
      recv_wait_left <= 0;
      recv_quiet     <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (expected_dates_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d-%0d-%0d bad=%0b",
                                  result_year, result_month, result_day, bad_month));
      end else begin
        exp_r = expected_dates_q.pop_front();
        if (result_year !== exp_r.year)
          report_mismatch($sformatf("result_year %0d, expected %0d", result_year, exp_r.year));
        if (result_month !== exp_r.month)
          report_mismatch($sformatf("result_month %0d, expected %0d",
                                    result_month, exp_r.month));
        if (result_day !== exp_r.day)
          report_mismatch($sformatf("result_day %0d, expected %0d", result_day, exp_r.day));
        if (bad_month !== exp_r.bad)
          report_mismatch($sformatf("bad_month %0b, expected %0b", bad_month, exp_r.bad));
      end
      if ($urandom_range(0, 31) == 0) recv_quiet <= !recv_quiet;
      w = draw_wait(recv_quiet);
      out_ready      <= (w == 0);
      recv_wait_left <= (w == 0) ? 0 : w - 1;
    end else if (!out_ready) begin
      if (recv_wait_left != 0) recv_wait_left <= recv_wait_left - 1;
      else out_ready <= 1'b1;
    end
  end

  initial begin
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned a;
    rst_ni       = 1'b0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    send_quiet   = 1'b0;

    // Directed: leap rules, month and year carries, odd days, invalid months, field extremes.
    queue_date(2000, 2, 29, 0);
    queue_date(1900, 2, 29, 0);
    queue_date(2100, 2, 28, 1);
    queue_date(2400, 2, 28, 1);
    queue_date(2000, 12, 31, 1);
    queue_date(1999, 12, 31, 366);
    queue_date(1, 1, 1, 0);
    queue_date(0, 1, 0, 0);
    queue_date(2024, 3, 0, 0);
    queue_date(2023, 4, 31, 0);
    queue_date(2023, 2, 31, 0);
    queue_date(9999, 12, 31, 32767);
    queue_date(16383, 12, 31, 32767);
    queue_date(16383, 1, 0, 0);
    queue_date(0, 12, 31, 32767);
    queue_date(2023, 0, 15, 100);
    queue_date(2023, 13, 1, 5);
    queue_date(1, 14, 0, 0);
    queue_date(16383, 15, 31, 32767);
    queue_date(0, 0, 0, 0);
    queue_date(2023, 6, 30, 1);
    queue_date(2023, 11, 30, 31);

    for (int i = 0; i < 500; i++) begin
      if (i % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0, 1, 2:  y = $urandom_range(0, 16383);
        3, 4, 5:  y = 100 * $urandom_range(0, 99) + $urandom_range(0, 2) - 1;
        default:  y = $urandom_range(1, 9999);
      endcase
      if (y > 16383) y = 0;
      if ($urandom_range(0, 9) == 0) m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
      else m = $urandom_range(1, 12);
      d = ($urandom_range(0, 4) == 0) ? $urandom_range(27, 31) : $urandom_range(0, 31);
      case ($urandom_range(0, 19))
        0:                    a = 32767;
        1, 2, 3, 4:           a = $urandom_range(0, 32767);
        5, 6, 7, 8, 9:        a = $urandom_range(0, 3000);
        default:              a = $urandom_range(0, 400);
      endcase
      queue_date(y, m, d, a);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_dates_q.size() != 0 || in_valid || expected_dates_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_dates_q.size() == 0) begin
      $display("gregorian_date_add_days regression: pass");
    end else begin
      $display("gregorian_date_add_days regression: fail");
    end
    $finish;
  end

endmodule
